// ===== design/in_range_interval_detector_unit_macros.svh =====
// Assertion macros shared by the in-range interval detector RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef IN_RANGE_INTERVAL_DETECTOR_UNIT_MACROS_SVH
`define IN_RANGE_INTERVAL_DETECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define IRID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("irid assertion failed");

// Next-cycle implication, disabled during reset
`define IRID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("irid assertion failed");

`else

`define IRID_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IRID_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/irid_pkg.sv =====
// Package for the in-range interval detector: field types, record and
// configuration structures, register indexes and default widths. No dependencies.
`default_nettype none

package irid_pkg;

	// Fixed widths of the stream fields
	localparam int FIELD_BITS   = 32;
	localparam int SUM_DUR_BITS = 40;
	localparam int CFG_IDX_BITS = 2;

	// Defaults for the top-level parameters
	localparam int TIME_BITS_DEFAULT  = 32;
	localparam int COUNT_BITS_DEFAULT = 32;

	typedef logic [FIELD_BITS-1:0]   field_t;
	typedef logic [SUM_DUR_BITS-1:0] sum_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// Register indexes of the configuration channel
	localparam cfg_idx_t CFG_LOW_BOUND    = 2'd0;
	localparam cfg_idx_t CFG_HIGH_BOUND   = 2'd1;
	localparam cfg_idx_t CFG_MIN_DURATION = 2'd2;

	typedef enum logic {
		KIND_INTERVAL = 1'b0,
		KIND_SUMMARY  = 1'b1
	} record_kind_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] low_bound;
		logic signed [FIELD_BITS-1:0] high_bound;
		field_t                       min_duration;
	} cfg_t;

	typedef struct packed {
		record_kind_t record_kind;
		field_t       interval_number;
		field_t       begin_time;
		field_t       end_time;
		field_t       duration_seconds;
		field_t       sample_count;
		sum_t         duration_total;
		field_t       total_in_range;
		field_t       total_samples;
		logic         last_of_run;
	} record_t;

endpackage

`default_nettype wire

// ===== design/irid_core.sv =====
// Per-sample run tracking: window test, run state, totals and record build.
// Depends on irid_pkg and the assertion macro header.
`default_nettype none

`include "in_range_interval_detector_unit_macros.svh"

module irid_core #(
	parameter int TIME_BITS  = irid_pkg::TIME_BITS_DEFAULT,
	parameter int COUNT_BITS = irid_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  go,
	input  wire logic signed [31:0]    temperature,
	input  wire irid_pkg::field_t      timestamp,
	input  wire logic                  end_of_stream,
	input  wire irid_pkg::cfg_t        cfg,
	output logic [1:0]                 push_n,
	output irid_pkg::record_t          rec0,
	output irid_pkg::record_t          rec1
);

	localparam int CMP_BITS = (TIME_BITS > irid_pkg::FIELD_BITS) ? TIME_BITS
		: irid_pkg::FIELD_BITS;
	localparam int SUM_W = ((TIME_BITS > irid_pkg::SUM_DUR_BITS) ? TIME_BITS
		: irid_pkg::SUM_DUR_BITS) + 1;
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'({irid_pkg::SUM_DUR_BITS{1'b1}});

	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	function automatic count_t sat_inc(input count_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Run state and totals
	logic                in_interval_q;
	time_t               run_begin_q;
	count_t              run_count_q;
	count_t              reported_q;
	irid_pkg::sum_t      sum_dur_q;
	count_t              sum_in_range_q;
	count_t              sum_samples_q;

	logic                hit;
	logic                close_run;
	logic                eos_open;
	logic                add_run;
	logic                emit_iv;
	time_t               ts;
	time_t               dur;
	time_t               dur_eff;
	time_t               begin_eff;
	count_t              cnt_inc;
	count_t              cnt_eff;
	count_t              samples_nxt;
	count_t              in_range_nxt;
	count_t              reported_nxt;
	logic [COUNT_BITS:0] in_range_wide;
	logic [SUM_W-1:0]    sum_dur_wide;
	irid_pkg::sum_t      sum_dur_nxt;
	irid_pkg::record_t   iv_rec;
	irid_pkg::record_t   sum_rec;

	// Window test and run bookkeeping for the current sample
	always_comb begin
		ts        = TIME_BITS'(timestamp);
		hit       = (temperature >= cfg.low_bound) && (temperature <= cfg.high_bound);
		dur       = ts - run_begin_q;
		cnt_inc   = sat_inc(run_count_q);
		close_run = !hit && in_interval_q;
		eos_open  = end_of_stream && hit;
		add_run   = close_run || eos_open;

		// Count, start and length of the run that is closed or flushed now
		cnt_eff   = close_run ? run_count_q : (in_interval_q ? cnt_inc : COUNT_BITS'(1));
		begin_eff = in_interval_q ? run_begin_q : ts;
		dur_eff   = in_interval_q ? dur : '0;

		emit_iv = eos_open || (close_run && (CMP_BITS'(dur) >= CMP_BITS'(cfg.min_duration)));

		samples_nxt  = sat_inc(sum_samples_q);
		reported_nxt = emit_iv ? sat_inc(reported_q) : reported_q;

		in_range_wide = {1'b0, sum_in_range_q} + {1'b0, cnt_eff};
		if (!add_run) begin
			in_range_nxt = sum_in_range_q;
		end else if (in_range_wide[COUNT_BITS]) begin
			in_range_nxt = '1;
		end else begin
			in_range_nxt = in_range_wide[COUNT_BITS-1:0];
		end

		sum_dur_wide = SUM_W'(sum_dur_q) + SUM_W'(dur_eff);
		if (!add_run) begin
			sum_dur_nxt = sum_dur_q;
		end else if (sum_dur_wide > SUM_MAX) begin
			sum_dur_nxt = '1;
		end else begin
			sum_dur_nxt = irid_pkg::sum_t'(sum_dur_wide);
		end
	end

	// Build the interval and summary records
	always_comb begin
		iv_rec.record_kind      = irid_pkg::KIND_INTERVAL;
		iv_rec.interval_number  = irid_pkg::field_t'(reported_nxt);
		iv_rec.begin_time       = irid_pkg::field_t'(begin_eff);
		iv_rec.end_time         = irid_pkg::field_t'(ts);
		iv_rec.duration_seconds = irid_pkg::field_t'(dur_eff);
		iv_rec.sample_count     = irid_pkg::field_t'(cnt_eff);
		iv_rec.duration_total   = '0;
		iv_rec.total_in_range   = irid_pkg::field_t'(in_range_nxt);
		iv_rec.total_samples    = irid_pkg::field_t'(samples_nxt);
		iv_rec.last_of_run      = !end_of_stream;

		sum_rec.record_kind      = irid_pkg::KIND_SUMMARY;
		sum_rec.interval_number  = irid_pkg::field_t'(reported_nxt);
		sum_rec.begin_time       = '0;
		sum_rec.end_time         = '0;
		sum_rec.duration_seconds = '0;
		sum_rec.sample_count     = '0;
		sum_rec.duration_total   = sum_dur_nxt;
		sum_rec.total_in_range   = irid_pkg::field_t'(in_range_nxt);
		sum_rec.total_samples    = irid_pkg::field_t'(samples_nxt);
		sum_rec.last_of_run      = 1'b1;

		rec0   = emit_iv ? iv_rec : sum_rec;
		rec1   = sum_rec;
		push_n = {1'b0, emit_iv} + {1'b0, end_of_stream};
	end

	// Commit the sample; end of stream returns the state to its reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_interval_q  <= 1'b0;
			run_begin_q    <= '0;
			run_count_q    <= COUNT_BITS'(1);
			reported_q     <= '0;
			sum_dur_q      <= '0;
			sum_in_range_q <= '0;
			sum_samples_q  <= '0;
		end else if (go) begin
			if (end_of_stream) begin
				in_interval_q  <= 1'b0;
				run_begin_q    <= '0;
				run_count_q    <= COUNT_BITS'(1);
				reported_q     <= '0;
				sum_dur_q      <= '0;
				sum_in_range_q <= '0;
				sum_samples_q  <= '0;
			end else begin
				in_interval_q  <= hit;
				if (hit && !in_interval_q) begin
					run_begin_q <= ts;
				end
				if (hit && in_interval_q) begin
					run_count_q <= cnt_inc;
				end else if (close_run) begin
					run_count_q <= COUNT_BITS'(1);
				end
				reported_q     <= reported_nxt;
				sum_dur_q      <= sum_dur_nxt;
				sum_in_range_q <= in_range_nxt;
				sum_samples_q  <= samples_nxt;
			end
		end
	end

	// A run out of interval always has a fresh sample count
	`IRID_ASSERT_IMP(a_idle_count_one, clk, arst_n, !in_interval_q, run_count_q == COUNT_BITS'(1))
	// A committed end-of-stream sample leaves the run closed
	`IRID_ASSERT_NXT(a_eos_clears, clk, arst_n, go && end_of_stream, !in_interval_q && (sum_samples_q == '0))

endmodule

`default_nettype wire

// ===== design/irid_outq.sv =====
// Two-entry result queue: takes up to two records per cycle as room allows, sends one while out_ready is high.
// Depends on irid_pkg and the assertion macro header.
`default_nettype none

`include "in_range_interval_detector_unit_macros.svh"

module irid_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_n,
	input  wire irid_pkg::record_t rec0,
	input  wire irid_pkg::record_t rec1,
	output logic [1:0]             free_n,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output irid_pkg::record_t      out_rec
);

	irid_pkg::record_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_rec   = entry_q[rd_ptr_q];
	assign free_n    = 2'd2 - count_q;

	// Store the records of a committed sample in order
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_ptr_q] <= rec0;
		end
		if (push_n == 2'd2) begin
			entry_q[~wr_ptr_q] <= rec1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push_n[0];
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q  <= count_q + push_n - {1'b0, pop};
		end
	end

	`IRID_ASSERT_IMP(a_no_overflow, clk, arst_n, 1'b1, count_q <= 2'd2)
	`IRID_ASSERT_IMP(a_push_fits, clk, arst_n, push_n != 2'd0, push_n <= free_n)
	`IRID_ASSERT_NXT(a_pop_drains, clk, arst_n, pop && (push_n == 2'd0), count_q == $past(count_q) - 2'd1)

endmodule

`default_nettype wire

// ===== design/in_range_interval_detector_unit.sv =====
// Top level of the in-range interval detector: stream ports, configuration
// registers and input stage. Depends on irid_pkg, irid_core, irid_outq, macros.
//
// Usage:
//  - s_axis carries samples; m_axis carries interval and summary records.
//    tlast on the input marks the end-of-stream sample; on the output it
//    marks the last record caused by one sample. m_axis_tuser is the kind.
//  - cfg writes set low_bound, high_bound and min_duration_seconds; they
//    are always accepted and should be made only while the block is idle.
//  - A transfer lands in the input stage; once the result queue has room it is
//    processed against the run state and its records enter a two-entry
//    result queue, which drives tvalid from its registered occupancy.
//  - One sample per cycle is sustained while m_axis_tready stays high and each
//    sample yields at most one record; a sample that yields two records holds
//    the input stage until the result queue is empty, bounded by the output
//    port of one record a cycle.
//  - When m_axis stalls the queue fills and s_axis_tready drops; nothing is
//    lost. tready on the input does not depend on m_axis_tready.
//  - Reset clears run state, totals, configuration and both stages.
`default_nettype none

`include "in_range_interval_detector_unit_macros.svh"

module in_range_interval_detector_unit #(
	parameter int TIME_BITS  = irid_pkg::TIME_BITS_DEFAULT,
	parameter int COUNT_BITS = irid_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Sample stream
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [63:0]              s_axis_tdata,  // temperature, timestamp
	input  wire logic                     s_axis_tlast,  // end_of_stream
	// Record stream
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// interval_number, begin_time, end_time, duration_seconds, sample_count,
	// duration_total, total_in_range, total_samples
	output logic [263:0]                  m_axis_tdata,
	output logic                          m_axis_tuser,  // record_kind
	output logic                          m_axis_tlast,  // last_of_run
	// Configuration writes
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire irid_pkg::cfg_idx_t       cfg_index,
	input  wire irid_pkg::field_t         cfg_data
);

	irid_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	logic signed [31:0] temp_s1;
	irid_pkg::field_t  ts_s1;
	logic              eos_s1;
	logic              go;
	logic              accept;
	logic [1:0]        push_n;
	logic [1:0]        push_go;
	logic [1:0]        free_n;
	irid_pkg::record_t rec0;
	irid_pkg::record_t rec1;
	irid_pkg::record_t out_rec;

	assign cfg_ready     = 1'b1;
	assign go            = valid_s1 && (push_n <= free_n);
	assign s_axis_tready = !valid_s1 || go;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Only a committed sample pushes its records
	assign push_go       = go ? push_n : 2'd0;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				irid_pkg::CFG_LOW_BOUND:    cfg_q.low_bound    <= cfg_data;
				irid_pkg::CFG_HIGH_BOUND:   cfg_q.high_bound   <= cfg_data;
				irid_pkg::CFG_MIN_DURATION: cfg_q.min_duration <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: hold the sample until the result queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			temp_s1 <= $signed(s_axis_tdata[31:0]);
			ts_s1   <= s_axis_tdata[63:32];
			eos_s1  <= s_axis_tlast;
		end
	end

	irid_core #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.temperature   (temp_s1),
		.timestamp     (ts_s1),
		.end_of_stream (eos_s1),
		.cfg           (cfg_q),
		.push_n        (push_n),
		.rec0          (rec0),
		.rec1          (rec1)
	);

	irid_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_go),
		.rec0      (rec0),
		.rec1      (rec1),
		.free_n    (free_n),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rec   (out_rec)
	);

	// Pack the record onto the output stream
	assign m_axis_tuser = out_rec.record_kind;
	assign m_axis_tlast = out_rec.last_of_run;
	assign m_axis_tdata = {out_rec.total_samples, out_rec.total_in_range,
		out_rec.duration_total, out_rec.sample_count, out_rec.duration_seconds,
		out_rec.end_time, out_rec.begin_time, out_rec.interval_number};

	// A summary record always closes the records of its sample
	`IRID_ASSERT_IMP(a_summary_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	// An end-of-stream sample always yields at least the summary
	`IRID_ASSERT_IMP(a_eos_records, clk, arst_n, valid_s1 && eos_s1, push_n != 2'd0)

endmodule

`default_nettype wire
